// ----- hdl/drcr_pkg.sv -----
// drcr_pkg: shared types and constants for the drive current ramp controller
// no dependencies; imported by drcr_cfg, drcr_step and the top level
package drcr_pkg;

	localparam int CODE_W   = 12;
	localparam int LEVEL_W  = 12;
	localparam int REG_IDX_W = 2;

	localparam logic [CODE_W-1:0] CODE_TOP = 12'hFFF;
	localparam logic signed [LEVEL_W:0] DEADBAND = 13'sd4;

	localparam logic [LEVEL_W-1:0] TARGET_RST = 12'd0;
	localparam logic [LEVEL_W-1:0] MIN_RST    = 12'd0;
	localparam logic [LEVEL_W-1:0] MAX_RST    = 12'd4095;
	localparam logic [CODE_W-1:0]  START_RST  = 12'd1395;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_UP   = 2'd1,
		MODE_DOWN = 2'd2,
		MODE_TUNE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_START  = 2'd1,
		ACT_STOP   = 2'd2,
		ACT_RETUNE = 2'd3
	} action_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TARGET = 2'd0,
		REG_MIN    = 2'd1,
		REG_MAX    = 2'd2,
		REG_START  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] target_level;
		logic [LEVEL_W-1:0] min_level;
		logic [LEVEL_W-1:0] max_level;
		logic [CODE_W-1:0]  start_code;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic              enable;
		logic [CODE_W-1:0] code;
	} drv_state_t;

endpackage

// ----- hdl/drcr_cfg.sv -----
// drcr_cfg: configuration register file, write only
// depends on drcr_pkg
module drcr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [drcr_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [drcr_pkg::LEVEL_W-1:0]   cfg_wdata,
	output drcr_pkg::cfg_t                cfg
);
	import drcr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_level <= TARGET_RST;
			cfg_q.min_level    <= MIN_RST;
			cfg_q.max_level    <= MAX_RST;
			cfg_q.start_code   <= START_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_TARGET: cfg_q.target_level <= cfg_wdata;
				REG_MIN:    cfg_q.min_level    <= cfg_wdata;
				REG_MAX:    cfg_q.max_level    <= cfg_wdata;
				REG_START:  cfg_q.start_code   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/drcr_step.sv -----
// drcr_step: ramp state registers and the per-tick step logic
// depends on drcr_pkg; the state registers double as the result register
module drcr_step (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [1:0]                   action,
	input  logic [drcr_pkg::LEVEL_W-1:0] sample,
	input  drcr_pkg::cfg_t               cfg,
	output drcr_pkg::drv_state_t         state
);
	import drcr_pkg::*;

	drv_state_t state_q;
	drv_state_t pre;
	drv_state_t nxt;
	logic signed [LEVEL_W:0] diff;
	logic in_band;

	always_comb begin
		pre = state_q;
		unique case (action_t'(action))
			ACT_START: begin
				pre.code   = cfg.start_code;
				pre.enable = 1'b1;
				pre.mode   = MODE_UP;
			end
			ACT_STOP: pre.mode = MODE_DOWN;
			ACT_RETUNE: begin
				if (cfg.target_level < cfg.max_level && cfg.target_level > cfg.min_level)
					pre.mode = MODE_TUNE;
			end
			default: ;
		endcase
	end

	// target minus sample
	assign diff = $signed({1'b0, cfg.target_level}) - $signed({1'b0, sample});
	assign in_band = (diff <= DEADBAND) && (diff >= -DEADBAND);

	always_comb begin
		nxt = pre;
		unique case (pre.mode)
			MODE_UP: begin
				if (sample >= cfg.target_level) begin
					nxt.mode = MODE_IDLE;
				end else if (pre.code < CODE_TOP) begin
					nxt.code = pre.code + 1'b1;
				end else begin
					nxt.code = CODE_TOP;
					nxt.mode = MODE_IDLE;
				end
			end
			MODE_DOWN: begin
				if (sample <= cfg.min_level) begin
					nxt.enable = 1'b0;
					nxt.mode   = MODE_IDLE;
				end else if (pre.code > cfg.start_code) begin
					nxt.code = pre.code - 1'b1;
				end else begin
					nxt.code   = '0;
					nxt.enable = 1'b0;
					nxt.mode   = MODE_IDLE;
				end
			end
			MODE_TUNE: begin
				priority if (in_band) begin
					nxt.mode = MODE_IDLE;
				end else if (diff < 0 && pre.code > cfg.start_code) begin
					nxt.code = pre.code - 1'b1;
				end else if (diff > 0 && pre.code < CODE_TOP) begin
					nxt.code = pre.code + 1'b1;
				end else begin
					nxt.mode = MODE_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode   <= MODE_IDLE;
			state_q.enable <= 1'b0;
			state_q.code   <= '0;
		end else if (adv) begin
			state_q <= nxt;
		end
	end

	assign state = state_q;

	a_up_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_UP |-> state_q.enable)
		else $error("ramp up without drive enable");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("state moved without a step");

	a_enable_drop_on_down: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q.enable) |-> $past(adv && pre.mode == MODE_DOWN))
		else $error("enable dropped outside a ramp-down step");

endmodule

// ----- hdl/drive_current_ramp_controller.sv -----
// drive_current_ramp_controller: top level with the input register and stream handshake
// depends on drcr_pkg, drcr_cfg and drcr_step
//
// One tick beat is taken every clock cycle while results are taken as fast; a result
// is offered once its tick has passed the input register and the step logic has written
// the ramp state, which is also the result register; a result not taken stalls the step.
// The state register holds a finished result while the next tick waits in the input register.
// Configuration writes take effect on the next clock edge.
module drive_current_ramp_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,  // action[1:0], sample[13:2], zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,  // dac_code[11:0], drive_enable[12], mode[14:13]
	input  logic                          cfg_we,
	input  logic [drcr_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [drcr_pkg::LEVEL_W-1:0]   cfg_wdata
);
	import drcr_pkg::*;

	logic               vld_s1;
	logic [1:0]         action_s1;
	logic [LEVEL_W-1:0] sample_s1;
	logic               out_vld_q;
	logic               adv;
	cfg_t               cfg;
	drv_state_t         state;

	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s_tready)
				vld_s1 <= s_tvalid;
			if (adv)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tdata[1:0];
			sample_s1 <= s_tdata[13:2];
		end
	end

	drcr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	drcr_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.action (action_s1),
		.sample (sample_s1),
		.cfg    (cfg),
		.state  (state)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, state.mode, state.enable, state.code};

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for drive_current_ramp_controller, stream ticks in, drive state out
// depends on drcr_pkg and the rtl; a scoreboard class tracks the ramp state per accepted beat
`timescale 1ns / 100ps

module tb;
	import drcr_pkg::*;

	localparam int LONG_HOLD = 120;

	typedef struct packed {
		mode_t             mode;
		logic              en;
		logic [CODE_W-1:0] code;
	} drive_t;

	class ramp_checker;
		logic [LEVEL_W-1:0] target_level, min_level, max_level;
		logic [CODE_W-1:0]  start_code, code;
		logic               en;
		mode_t              mode;
		drive_t             pending_drive[$];
		int                 errors;

		function new();
			target_level = TARGET_RST;
			min_level    = MIN_RST;
			max_level    = MAX_RST;
			start_code   = START_RST;
			code         = '0;
			en           = 1'b0;
			mode         = MODE_IDLE;
			errors       = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [LEVEL_W-1:0] val);
			case (idx)
				REG_TARGET: target_level = val;
				REG_MIN:    min_level = val;
				REG_MAX:    max_level = val;
				REG_START:  start_code = val;
				default: ;
			endcase
		endfunction

		function void take_tick(action_t act, logic [LEVEL_W-1:0] smp);
			int     t, s;
			drive_t d;
			t = int'(target_level);
			s = int'(smp);
			case (act)
				ACT_START: begin
					code = start_code;
					en   = 1'b1;
					mode = MODE_UP;
				end
				ACT_STOP: mode = MODE_DOWN;
				ACT_RETUNE: begin
					if (target_level < max_level && target_level > min_level)
						mode = MODE_TUNE;
				end
				default: ;
			endcase
			case (mode)
				MODE_UP: begin
					if (smp >= target_level)
						mode = MODE_IDLE;
					else if (code < CODE_TOP)
						code = code + 1'b1;
					else begin
						code = CODE_TOP;
						mode = MODE_IDLE;
					end
				end
				MODE_DOWN: begin
					if (smp <= min_level) begin
						en   = 1'b0;
						mode = MODE_IDLE;
					end else if (code > start_code)
						code = code - 1'b1;
					else begin
						code = '0;
						en   = 1'b0;
						mode = MODE_IDLE;
					end
				end
				MODE_TUNE: begin
					if (t <= s + int'(DEADBAND) && t >= s - int'(DEADBAND))
						mode = MODE_IDLE;
					else if (t < s && code > start_code)
						code = code - 1'b1;
					else if (t > s && code < CODE_TOP)
						code = code + 1'b1;
					else
						mode = MODE_IDLE;
				end
				default: ;
			endcase
			d.mode = mode;
			d.en   = en;
			d.code = code;
			pending_drive.push_back(d);
		endfunction

		function void check_drive(logic [15:0] data);
			drive_t want;
			if (pending_drive.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output beat %h", data);
				return;
			end
			want = pending_drive.pop_front();
			if (data[11:0] !== want.code || data[12] !== want.en || data[14:13] !== want.mode) begin
				errors++;
				if (errors <= 10)
					$display("drive mismatch: code %0d/%0d enable %0b/%0b mode %0d/%0d (exp/act)",
						want.code, data[11:0], want.en, data[12], want.mode, data[14:13]);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid, s_tready;
	logic [15:0]          s_tdata;
	logic                 m_tvalid, m_tready;
	logic [15:0]          m_tdata;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_addr;
	logic [LEVEL_W-1:0]   cfg_wdata;

	ramp_checker chk;
	int          n_accepted = 0;
	bit          tx_fast = 1'b0;
	bit          rx_fast = 1'b0;
	bit          rx_held = 1'b0;

	drive_current_ramp_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			chk.take_tick(action_t'(s_tdata[1:0]), s_tdata[13:2]);
			n_accepted++;
		end
		if (arst_n && m_tvalid && m_tready)
			chk.check_drive(m_tdata);
	end

	// output side backpressure, with one long hold once traffic is flowing
	initial begin
		int r;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			r = $urandom_range(99, 0);
			if (!rx_held && n_accepted >= 300) begin
				rx_held = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (rx_fast || r < 65) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(6, 1)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (r < 95 ? $urandom_range(3, 1) : $urandom_range(40, 8)) @(posedge clk);
			end
		end
	end

	function automatic logic [LEVEL_W-1:0] pick(int lo_v, int hi_v);
		if (lo_v < 0) lo_v = 0;
		if (lo_v > 4095) lo_v = 4095;
		if (hi_v > 4095) hi_v = 4095;
		if (hi_v < lo_v) hi_v = lo_v;
		return LEVEL_W'($urandom_range(hi_v, lo_v));
	endfunction

	task automatic send_tick(action_t act, logic [LEVEL_W-1:0] smp);
		if (!tx_fast && $urandom_range(99, 0) < 25) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(9, 0) < 8 ? $urandom_range(3, 1) : $urandom_range(30, 10))
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, smp, act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chk.pending_drive.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(logic [LEVEL_W-1:0] tgt, mn, mx, st);
		logic [LEVEL_W-1:0] vals[4];
		vals = '{tgt, mn, mx, st};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= reg_idx_t'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			chk.set_reg(reg_idx_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int quota);
		int t, mn, kind, len, sent;
		t    = int'(chk.target_level);
		mn   = int'(chk.min_level);
		sent = 0;
		while (sent < quota) begin
			kind = $urandom_range(9, 0);
			len  = $urandom_range(14, 2);
			if (kind < 4) begin
				send_tick(ACT_START, pick(0, t - 1));
				for (int i = 0; i < len; i++)
					send_tick(ACT_TICK, i == len - 1 ? pick(t, t + 8) : pick(t - 40, t - 1));
			end else if (kind < 6) begin
				send_tick(ACT_STOP, pick(mn + 1, 4095));
				for (int i = 0; i < len; i++)
					send_tick(ACT_TICK, (i == len - 1 && $urandom_range(1, 0)) ?
						pick(0, mn) : pick(mn + 1, mn + 200));
			end else if (kind < 8) begin
				send_tick(ACT_RETUNE, pick(t - 30, t + 30));
				for (int i = 0; i < len; i++)
					send_tick(ACT_TICK, pick(t - 12, t + 12));
			end else begin
				for (int i = 0; i < len; i++)
					send_tick(action_t'($urandom_range(3, 0)), LEVEL_W'($urandom()));
			end
			sent += len + 1;
		end
	endtask

	initial begin
		int tg, mn, mx;
		chk = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_addr  <= REG_TARGET;
		cfg_wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle tick, rejected retune, start already at target
		send_tick(ACT_TICK, 12'd0);
		send_tick(ACT_RETUNE, 12'd0);
		send_tick(ACT_START, 12'd0);
		settle();

		// start code near the top: saturation, floor shutdown, tune blocked at the start code
		write_regs(12'd2000, 12'd100, 12'd4095, 12'd4093);
		send_tick(ACT_START, 12'd0);
		send_tick(ACT_TICK, 12'd0);
		send_tick(ACT_TICK, 12'd0);
		send_tick(ACT_STOP, 12'd4095);
		send_tick(ACT_TICK, 12'd4095);
		send_tick(ACT_TICK, 12'd4095);
		send_tick(ACT_START, 12'd4095);
		send_tick(ACT_STOP, 12'd50);
		send_tick(ACT_RETUNE, 12'd0);
		send_tick(ACT_TICK, 12'd4095);
		send_tick(ACT_TICK, 12'd4095);
		send_tick(ACT_RETUNE, 12'd1996);
		send_tick(ACT_RETUNE, 12'd2005);
		send_tick(ACT_START, 12'd0);
		send_tick(ACT_RETUNE, 12'd0);
		send_tick(ACT_STOP, 12'd4095);
		send_tick(ACT_START, 12'd4095);

		for (int p = 0; p < 9; p++) begin
			settle();
			case (p)
				0: write_regs(12'd0, 12'd0, 12'd0, 12'd0);
				1: write_regs(12'd4095, 12'd4095, 12'd4095, 12'd4095);
				2: write_regs(12'd4000, 12'd10, 12'd4095, 12'd4088);
				3: write_regs(12'd2048, 12'd1000, 12'd3000, 12'd2040);
				4: write_regs(12'd1, 12'd0, 12'd2, START_RST);
				8: write_regs(12'd3000, 12'd3000, 12'd4095, 12'd0);
				default: begin
					tg = $urandom_range(4095, 0);
					mn = $urandom_range(tg, 0);
					mx = $urandom_range(4095, tg);
					write_regs(LEVEL_W'(tg), LEVEL_W'(mn), LEVEL_W'(mx),
						LEVEL_W'($urandom()));
				end
			endcase
			tx_fast = ($urandom_range(3, 0) == 0);
			rx_fast = ($urandom_range(3, 0) == 0);
			run_phase(80);
		end
		settle();

		if (chk.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
